// ----- design/svpp_pkg.sv -----
package svpp_pkg;

  typedef enum logic [1:0] {
    CMD_PLAY   = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_DESC   = 2'd2,
    CMD_FRAME  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_DESC = 3'd1,
    S_SAMP = 3'd2,
    S_ADDR = 3'd3,
    S_DATA = 3'd4,
    S_OUT  = 3'd5
  } state_t;

endpackage

// ----- design/svpp_ram.sv -----
module svpp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/sample_voice_pool_player_unit.sv -----
// play, sample write and descriptor write: result registered in the cycle after the beat,
// one item per cycle while the output is free and no frame is in progress
// frame: each voice of the pair walks voice memory, descriptor memory and sample memory
// in turn, one synchronous read each plus an address step; input stalls until it is done
// reset: all voices free, effects enabled, output empty; memories are not cleared
module sample_voice_pool_player_unit
  import svpp_pkg::*;
#(
  parameter int VOICE_COUNT  = 8,
  parameter int SOUND_COUNT  = 16,
  parameter int SAMPLE_WORDS = 65536
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               effects_enable,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic [3:0]         sound_id,
  input  logic [15:0]        sample_addr,
  input  logic signed [15:0] sample_value,
  input  logic [15:0]        sound_length,
  input  logic [1:0]         pair_select,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] left_sample,
  output logic signed [15:0] right_sample,
  output logic               play_accepted,
  output logic [2:0]         play_voice
);

  localparam int VAW = $clog2(VOICE_COUNT);
  localparam int SW  = (SOUND_COUNT > 1) ? $clog2(SOUND_COUNT) : 1;
  localparam int SAW = $clog2(SAMPLE_WORDS);
  localparam int VW  = SW + 16;
  localparam logic [63:0] RECIP = (64'd1 << 32) / 64'(SAMPLE_WORDS);
  localparam logic [31:0] WORDS = 32'(SAMPLE_WORDS);

  state_t state, state_next;
  cmd_t   in_cmd;

  logic                   fx_enable;
  logic [VOICE_COUNT-1:0] voice_active, voice_active_next;
  logic                   out_valid_next;
  logic                   load_out;
  logic                   in_accept, out_room;

  logic [1:0]             pair_q;
  logic                   side;
  logic                   live_q;
  logic [SW-1:0]          cur_sound;
  logic [15:0]            cur_pos;
  logic [15:0]            sum_q;
  logic [7:0]             quot_q;
  logic signed [15:0]     res_left, res_right;

  logic signed [15:0]     out_left, out_right;
  logic                   out_acc;
  logic [2:0]             out_voice;

  logic                   free_found;
  logic [VAW-1:0]         free_idx;
  logic [31:0]            free_wide;
  logic                   play_ok, id_ok, addr_ok;
  logic [31:0]            id_wide, addr_wide;
  logic [31:0]            in_vwide, rgt_vwide, cur_vwide;
  logic [VAW-1:0]         cur_vidx;
  logic                   cur_live;
  logic [15:0]            pos_next, addr_sum;
  logic [63:0]            prod;
  logic [31:0]            rem, rem_fix;
  logic signed [15:0]     sample;

  logic                   vmem_we;
  logic [VAW-1:0]         vmem_waddr, vmem_raddr;
  logic [VW-1:0]          vmem_wdata, vmem_rdata;
  logic                   dmem_we;
  logic [31:0]            dmem_rdata;
  logic                   smem_we;
  logic [SAW-1:0]         smem_raddr;
  logic [15:0]            smem_rdata;

  assign cfg_ready = 1'b1;
  assign in_cmd    = cmd_t'(cmd);
  assign out_room  = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE) || (!out_room && in_cmd != CMD_FRAME);
  assign in_accept = in_valid && !in_stall;

  assign id_wide   = {28'b0, sound_id};
  assign id_ok     = id_wide < 32'(SOUND_COUNT);
  assign addr_wide = {16'b0, sample_addr};
  assign addr_ok   = addr_wide < WORDS;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = VOICE_COUNT - 1; i >= 0; i--) begin
      if (!voice_active[i]) begin
        free_found = 1'b1;
        free_idx   = VAW'(i);
      end
    end
  end

  assign free_wide = 32'(free_idx);
  assign play_ok   = fx_enable && id_ok && free_found;

  assign in_vwide  = {29'b0, pair_select, 1'b0};
  assign rgt_vwide = {29'b0, pair_q, 1'b1};
  assign cur_vwide = {29'b0, pair_q, side};
  assign cur_vidx  = cur_vwide[VAW-1:0];
  assign cur_live  = (cur_vwide < 32'(VOICE_COUNT)) && voice_active[cur_vidx];

  assign pos_next = cur_pos + 16'd1;
  assign addr_sum = dmem_rdata[31:16] + cur_pos;
  assign prod     = 64'(addr_sum) * RECIP;
  assign rem      = 32'(sum_q) - 32'(quot_q) * WORDS;
  assign rem_fix  = (rem >= WORDS) ? rem - WORDS : rem;
  assign sample   = live_q ? $signed(smem_rdata) : 16'sd0;

  assign vmem_raddr = (state == S_IDLE) ? in_vwide[VAW-1:0] : rgt_vwide[VAW-1:0];
  assign vmem_waddr = (state == S_IDLE) ? free_idx : cur_vidx;
  assign vmem_wdata = (state == S_IDLE) ? {id_wide[SW-1:0], 16'd0} : {cur_sound, pos_next};
  assign smem_raddr = rem_fix[SAW-1:0];

  svpp_ram #(.WIDTH(VW), .DEPTH(VOICE_COUNT)) u_voice_mem (
    .clk   (clk),
    .we    (vmem_we),
    .waddr (vmem_waddr),
    .wdata (vmem_wdata),
    .raddr (vmem_raddr),
    .rdata (vmem_rdata)
  );

  svpp_ram #(.WIDTH(32), .DEPTH(SOUND_COUNT)) u_desc_mem (
    .clk   (clk),
    .we    (dmem_we),
    .waddr (id_wide[SW-1:0]),
    .wdata ({sample_addr, sound_length}),
    .raddr (vmem_rdata[VW-1:16]),
    .rdata (dmem_rdata)
  );

  svpp_ram #(.WIDTH(16), .DEPTH(SAMPLE_WORDS)) u_sample_mem (
    .clk   (clk),
    .we    (smem_we),
    .waddr (addr_wide[SAW-1:0]),
    .wdata (sample_value),
    .raddr (smem_raddr),
    .rdata (smem_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_accept && in_cmd == CMD_FRAME) begin
          state_next = S_DESC;
        end
      end
      S_DESC: state_next = S_SAMP;
      S_SAMP: state_next = S_ADDR;
      S_ADDR: state_next = S_DATA;
      S_DATA: state_next = side ? S_OUT : S_DESC;
      S_OUT: begin
        if (out_room) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    load_out          = 1'b0;
    out_left          = 16'sd0;
    out_right         = 16'sd0;
    out_acc           = 1'b0;
    out_voice         = 3'd0;
    vmem_we           = 1'b0;
    dmem_we           = 1'b0;
    smem_we           = 1'b0;
    voice_active_next = voice_active;
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          case (in_cmd)
            CMD_PLAY: begin
              load_out = 1'b1;
              if (play_ok) begin
                out_acc                     = 1'b1;
                out_voice                   = free_wide[2:0];
                vmem_we                     = 1'b1;
                voice_active_next[free_idx] = 1'b1;
              end
            end
            CMD_SAMPLE: begin
              load_out = 1'b1;
              smem_we  = addr_ok;
            end
            CMD_DESC: begin
              load_out = 1'b1;
              dmem_we  = id_ok;
            end
            default: begin
            end
          endcase
        end
      end
      S_SAMP: begin
        if (live_q) begin
          vmem_we = 1'b1;
          if (pos_next == dmem_rdata[15:0]) begin
            voice_active_next[cur_vidx] = 1'b0;
          end
        end
      end
      S_OUT: begin
        if (out_room) begin
          load_out  = 1'b1;
          out_left  = res_left;
          out_right = res_right;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_next = load_out || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      voice_active <= '0;
      fx_enable    <= 1'b1;
    end else begin
      state        <= state_next;
      out_valid    <= out_valid_next;
      voice_active <= voice_active_next;
      if (cfg_valid && cfg_ready) begin
        fx_enable <= effects_enable;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_accept) begin
      pair_q <= pair_select;
      side   <= 1'b0;
    end
    if (state == S_DESC) begin
      live_q    <= cur_live;
      cur_sound <= vmem_rdata[VW-1:16];
      cur_pos   <= vmem_rdata[15:0];
    end
    if (state == S_SAMP) begin
      sum_q  <= addr_sum;
      quot_q <= prod[39:32];
    end
    if (state == S_DATA) begin
      if (!side) begin
        res_left <= sample;
      end else begin
        res_right <= sample;
      end
      side <= 1'b1;
    end
    if (load_out) begin
      left_sample   <= out_left;
      right_sample  <= out_right;
      play_accepted <= out_acc;
      play_voice    <= out_voice;
    end
  end

`ifndef SYNTH
  // a granted play marks its voice busy
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_accept && in_cmd == CMD_PLAY && play_ok)
      |=> voice_active[$past(free_idx)])
    else $error("played voice not marked active");

  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT || in_accept))
    else $error("result beat without a source");

  // frame result only after both voices of the pair
  assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> side)
    else $error("frame finished before right voice");

  assert property (@(posedge clk) disable iff (rst)
    vmem_we |-> (state == S_IDLE || (state == S_SAMP && live_q)))
    else $error("voice memory written outside play or advance");
`endif

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import svpp_pkg::*;

  localparam int VOICES = 8;
  localparam int SOUNDS = 16;
  localparam int WORDS  = 65536;

  typedef struct {
    cmd_t               cmd;
    logic [3:0]         sound_id;
    logic [15:0]        sample_addr;
    logic signed [15:0] sample_value;
    logic [15:0]        sound_length;
    logic [1:0]         pair_select;
  } pool_beat_t;

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               accepted;
    logic [2:0]         voice;
  } mix_result_t;

  class voice_pool_mirror;
    bit          enabled = 1'b1;
    bit          active [VOICES];
    logic [3:0]  voice_snd [VOICES];
    logic [15:0] voice_pos [VOICES];
    logic [15:0] snd_start [SOUNDS];
    logic [15:0] snd_size [SOUNDS];
    bit          snd_loaded [SOUNDS];
    logic [15:0] words [WORDS];
    bit          word_loaded [WORDS];
    mix_result_t due_results [$];
    int          mismatches, checked, plays_taken, frames_mixed;

    function logic [15:0] read_addr(int v);
      return snd_start[voice_snd[v]] + voice_pos[v];
    endfunction

    function logic [15:0] next_word(int v);
      logic [15:0] w;
      if (!active[v]) return 16'd0;
      w = words[read_addr(v)];
      voice_pos[v] = voice_pos[v] + 16'd1;
      if (voice_pos[v] == snd_size[voice_snd[v]]) active[v] = 1'b0;
      return w;
    endfunction

    function void apply_beat(pool_beat_t b);
      mix_result_t r;
      r.left     = '0;
      r.right    = '0;
      r.accepted = 1'b0;
      r.voice    = '0;
      case (b.cmd)
        CMD_PLAY: begin
          if (enabled) begin
            for (int v = 0; v < VOICES; v++) begin
              if (!active[v]) begin
                active[v]    = 1'b1;
                voice_snd[v] = b.sound_id;
                voice_pos[v] = '0;
                r.accepted   = 1'b1;
                r.voice      = 3'(v);
                plays_taken++;
                break;
              end
            end
          end
        end
        CMD_SAMPLE: begin
          words[b.sample_addr]       = b.sample_value;
          word_loaded[b.sample_addr] = 1'b1;
        end
        CMD_DESC: begin
          snd_start[b.sound_id]  = b.sample_addr;
          snd_size[b.sound_id]   = b.sound_length;
          snd_loaded[b.sound_id] = 1'b1;
        end
        default: begin
          r.left  = next_word(2 * int'(b.pair_select));
          r.right = next_word(2 * int'(b.pair_select) + 1);
          frames_mixed++;
        end
      endcase
      due_results.push_back(r);
    endfunction

    function void check_result(mix_result_t got);
      mix_result_t e;
      if (due_results.size() == 0) begin
        $error("result beat with nothing pending: left %0d right %0d", got.left, got.right);
        mismatches++;
        return;
      end
      e = due_results.pop_front();
      checked++;
      if (got.left !== e.left) begin
        $error("left_sample: expected %0d, got %0d", e.left, got.left);
        mismatches++;
      end
      if (got.right !== e.right) begin
        $error("right_sample: expected %0d, got %0d", e.right, got.right);
        mismatches++;
      end
      if (got.accepted !== e.accepted) begin
        $error("play_accepted: expected %0d, got %0d", e.accepted, got.accepted);
        mismatches++;
      end
      if (got.voice !== e.voice) begin
        $error("play_voice: expected %0d, got %0d", e.voice, got.voice);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               effects_enable;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         cmd;
  logic [3:0]         sound_id;
  logic [15:0]        sample_addr;
  logic signed [15:0] sample_value;
  logic [15:0]        sound_length;
  logic [1:0]         pair_select;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  logic               play_accepted;
  logic [2:0]         play_voice;

  voice_pool_mirror pool = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int beats_sent = 0;

  sample_voice_pool_player_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      pool.check_result(mix_result_t'{left_sample, right_sample, play_accepted, play_voice});
  end

  task automatic drive_beat(pool_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    cmd          <= b.cmd;
    sound_id     <= b.sound_id;
    sample_addr  <= b.sample_addr;
    sample_value <= b.sample_value;
    sound_length <= b.sound_length;
    pair_select  <= b.pair_select;
    do @(posedge clk); while (in_stall);
    pool.apply_beat(b);
    beats_sent++;
    @(negedge clk);
  endtask

  function automatic pool_beat_t noise_beat(cmd_t c);
    pool_beat_t b;
    b.cmd          = c;
    b.sound_id     = 4'($urandom);
    b.sample_addr  = 16'($urandom);
    b.sample_value = 16'($urandom);
    b.sound_length = 16'($urandom);
    b.pair_select  = 2'($urandom);
    return b;
  endfunction

  task automatic write_word(logic [15:0] addr, logic [15:0] val);
    pool_beat_t b;
    b = noise_beat(CMD_SAMPLE);
    b.sample_addr  = addr;
    b.sample_value = val;
    drive_beat(b);
  endtask

  task automatic load_sound(logic [3:0] id, logic [15:0] start, logic [15:0] len);
    pool_beat_t b;
    b = noise_beat(CMD_DESC);
    b.sound_id     = id;
    b.sample_addr  = start;
    b.sound_length = len;
    drive_beat(b);
  endtask

  // a sound is described before it is ever played
  task automatic play(logic [3:0] id);
    pool_beat_t b;
    if (!pool.snd_loaded[id]) load_sound(id, 16'($urandom), 16'($urandom_range(1, 12)));
    b = noise_beat(CMD_PLAY);
    b.sound_id = id;
    drive_beat(b);
  endtask

  // every word a live voice of the pair is about to read gets written first
  task automatic mix(logic [1:0] pair);
    pool_beat_t b;
    int v;
    for (int k = 0; k < 2; k++) begin
      v = 2 * int'(pair) + k;
      if (pool.active[v] && !pool.word_loaded[pool.read_addr(v)])
        write_word(pool.read_addr(v), 16'($urandom));
    end
    b = noise_beat(CMD_FRAME);
    b.pair_select = pair;
    drive_beat(b);
  endtask

  task automatic random_beat();
    int pick, v;
    logic [15:0] len;
    pick = $urandom_range(99);
    if (pick < 25) begin
      play(4'($urandom));
    end else if (pick < 40) begin
      write_word(16'($urandom), 16'($urandom));
    end else if (pick < 55) begin
      v = $urandom_range(VOICES - 1);
      // sometimes end a live voice on its next frame
      if (pool.active[v] && $urandom_range(3) == 0) begin
        load_sound(pool.voice_snd[v], 16'($urandom), pool.voice_pos[v] + 16'd1);
      end else begin
        case ($urandom_range(9))
          0: len = 16'd0;
          1, 2: len = 16'($urandom);
          default: len = 16'($urandom_range(1, 12));
        endcase
        load_sound(4'($urandom), 16'($urandom), len);
      end
    end else begin
      mix(2'($urandom));
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pool.due_results.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic set_effects(bit on);
    cfg_valid      <= 1'b1;
    effects_enable <= on;
    do @(posedge clk); while (!cfg_ready);
    pool.enabled = on;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst            = 1'b1;
    cfg_valid      = 1'b0;
    effects_enable = 1'b1;
    in_valid       = 1'b0;
    cmd            = '0;
    sound_id       = '0;
    sample_addr    = '0;
    sample_value   = '0;
    sound_length   = '0;
    pair_select    = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    set_effects(1'b1);
    send_idle_pct  = 26;
    recv_stall_pct = 83;

    load_sound(4'd0, 16'h0000, 16'd1);
    load_sound(4'd15, 16'hFFFE, 16'd4);
    load_sound(4'd1, 16'h8000, 16'd0);
    write_word(16'h0000, 16'h7FFF);
    write_word(16'hFFFE, 16'h8000);
    write_word(16'hFFFF, 16'hFFFF);
    write_word(16'h0001, 16'h0000);
    write_word(16'h8000, 16'h5555);
    play(4'd0);
    play(4'd15);
    mix(2'd0);
    mix(2'd0);
    // read address wraps past the top of memory
    mix(2'd0);
    play(4'd1);
    // fill the pool, the last play finds no free voice
    repeat (7) play(4'd0);
    // shorten below the live position, the voice plays on
    load_sound(4'd15, 16'hFFFE, 16'd1);
    mix(2'd0);
    mix(2'd3);
    mix(2'd1);

    while (beats_sent < 250) random_beat();
    drain();
    while (beats_sent < 480) random_beat();
    drain();
    set_effects(1'b0);
    send_idle_pct  = 83;
    recv_stall_pct = 26;
    while (beats_sent < 800) random_beat();
    drain();
    set_effects(1'b1);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 300;
    while (beats_sent < 1250) random_beat();
    drain();

    $display("%0d beats driven, %0d results checked, %0d plays took a voice, %0d frames mixed",
             beats_sent, pool.checked, pool.plays_taken, pool.frames_mixed);
    if (pool.mismatches == 0 && pool.due_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/svpp_pkg.sv
design/svpp_ram.sv
design/sample_voice_pool_player_unit.sv
test/testbench.sv
